// File: src/oqr_pkg.sv
// Package for the ordered queue with removal: sizes, operation and status codes,
// and the command type passed from the front end to the back end.
// Used by every module of the block; depends on nothing.
`default_nettype none

package oqr_pkg;

	// Queue sizing.
	localparam int DEPTH   = 16;
	localparam int ID_BITS = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// Port field widths.
	localparam int FUNC_W   = 3;
	localparam int UID_W    = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Command queue between front and back end.
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	// Operation codes, equal to the func encoding on the port.
	typedef enum logic [FUNC_W-1:0] {
		OP_APPEND = 3'd0,
		OP_REMOVE = 3'd1,
		OP_MARK   = 3'd2,
		OP_TEST   = 3'd3,
		OP_STATUS = 3'd4
	} op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	// One classified command.
	typedef struct packed {
		op_t               op;
		logic [ID_BITS-1:0] key;
	} cmd_t;

	// Occupancy flags of the command queue.
	typedef struct packed {
		logic full;
		logic empty;
	} cq_flags_t;

endpackage

`default_nettype wire

// File: src/oqr_front.sv
// Front end of the ordered queue: takes command transactions and classifies them.
// Unused function codes become status-only commands. Depends on oqr_pkg.
`default_nettype none

module oqr_front (
	input  wire logic                        start,
	input  wire logic [oqr_pkg::FUNC_W-1:0]  func,
	input  wire logic [oqr_pkg::UID_W-1:0]   user_id,
	input  wire oqr_pkg::cq_flags_t          cq_flags,
	output logic                             busy,
	output logic                             push,
	output oqr_pkg::cmd_t                    cmd
);

	// Accept whenever the command queue has room.
	assign busy = cq_flags.full;
	assign push = start && !cq_flags.full;

	// Classify the function code and trim the identifier to the stored width.
	always_comb begin
		cmd.key = oqr_pkg::ID_BITS'(user_id);
		case (func)
			oqr_pkg::OP_APPEND, oqr_pkg::OP_REMOVE, oqr_pkg::OP_MARK,
			oqr_pkg::OP_TEST: begin
				cmd.op = oqr_pkg::op_t'(func);
			end
			default: begin
				cmd.op = oqr_pkg::OP_STATUS;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/oqr_cmdq.sv
// Short command queue between the front and back ends of the ordered queue.
// Depth is set by oqr_pkg::CQ_DEPTH (a power of two). Depends on oqr_pkg.
`default_nettype none

module oqr_cmdq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire oqr_pkg::cmd_t      push_cmd,
	input  wire logic               pop,
	output oqr_pkg::cmd_t           head_cmd,
	output oqr_pkg::cq_flags_t      flags
);

	oqr_pkg::cmd_t                    slot_q [oqr_pkg::CQ_DEPTH];
	logic [oqr_pkg::CQ_PTR_W-1:0]     wr_ptr_q;
	logic [oqr_pkg::CQ_PTR_W-1:0]     rd_ptr_q;
	logic [oqr_pkg::CQ_CNT_W-1:0]     fill_q;

	assign flags.full  = (fill_q == oqr_pkg::CQ_CNT_W'(oqr_pkg::CQ_DEPTH));
	assign flags.empty = (fill_q == '0);
	assign head_cmd    = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// File: src/oqr_back.sv
// Back end of the ordered queue: a row of entry cells that compares every
// identifier at once, appends, removes with a shift, marks served and reports.
// Depends on oqr_pkg.
`default_nettype none

module oqr_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          run,
	input  wire oqr_pkg::cmd_t                 cmd,
	output logic                               done,
	output logic [oqr_pkg::STATUS_W-1:0]       status,
	output logic                               found,
	output logic [oqr_pkg::COUNT_W-1:0]        entry_count,
	output logic                               any_served,
	output logic                               all_served
);

	// Entry cells.
	logic [oqr_pkg::ID_BITS-1:0] ids_q [oqr_pkg::DEPTH];
	logic [oqr_pkg::DEPTH-1:0]   srv_q;
	logic [oqr_pkg::CNT_W-1:0]   cnt_q;

	// Next state of the cells.
	logic [oqr_pkg::ID_BITS-1:0] ids_d [oqr_pkg::DEPTH];
	logic [oqr_pkg::DEPTH-1:0]   srv_d;
	logic [oqr_pkg::CNT_W-1:0]   cnt_d;

	// Match information and result.
	logic [oqr_pkg::DEPTH-1:0]   vld;
	logic [oqr_pkg::DEPTH-1:0]   vld_d;
	logic [oqr_pkg::DEPTH-1:0]   hit;
	logic [oqr_pkg::DEPTH-1:0]   seen;
	logic                        hit_any;
	logic                        is_full;
	oqr_pkg::status_t            st;
	logic                        any_d;
	logic                        all_d;

	// Compare every occupied cell with the key; seen marks the first match and beyond.
	always_comb begin
		for (int i = 0; i < oqr_pkg::DEPTH; i++) begin
			vld[i] = (oqr_pkg::CNT_W'(i) < cnt_q);
			hit[i] = vld[i] && (ids_q[i] == cmd.key);
		end
		seen[0] = hit[0];
		for (int i = 1; i < oqr_pkg::DEPTH; i++) begin
			seen[i] = seen[i-1] | hit[i];
		end
		hit_any = |hit;
		is_full = (cnt_q == oqr_pkg::CNT_W'(oqr_pkg::DEPTH));
	end

	// Carry out the operation on the cells.
	always_comb begin
		ids_d = ids_q;
		srv_d = srv_q;
		cnt_d = cnt_q;
		st    = oqr_pkg::ST_OK;
		case (cmd.op)
			oqr_pkg::OP_APPEND: begin
				if (is_full) begin
					st = oqr_pkg::ST_FULL;
				end else begin
					ids_d[cnt_q[oqr_pkg::IDX_W-1:0]] = cmd.key;
					srv_d[cnt_q[oqr_pkg::IDX_W-1:0]] = 1'b0;
					cnt_d = cnt_q + 1'b1;
				end
			end
			oqr_pkg::OP_REMOVE: begin
				if (!hit_any) begin
					st = oqr_pkg::ST_MISS;
				end else begin
					for (int i = 0; i < oqr_pkg::DEPTH - 1; i++) begin
						if (seen[i]) begin
							ids_d[i] = ids_q[i+1];
							srv_d[i] = srv_q[i+1];
						end
					end
					if (seen[oqr_pkg::DEPTH-1]) begin
						srv_d[oqr_pkg::DEPTH-1] = 1'b0;
					end
					cnt_d = cnt_q - 1'b1;
				end
			end
			oqr_pkg::OP_MARK: begin
				if (!hit_any) begin
					st = oqr_pkg::ST_MISS;
				end else begin
					srv_d = srv_q | hit;
				end
			end
			oqr_pkg::OP_TEST: begin
				if (!hit_any) begin
					st = oqr_pkg::ST_MISS;
				end
			end
			default: begin
			end
		endcase
	end

	// Served summary over the occupied cells after the operation.
	always_comb begin
		for (int i = 0; i < oqr_pkg::DEPTH; i++) begin
			vld_d[i] = (oqr_pkg::CNT_W'(i) < cnt_d);
		end
		any_d = |(srv_d & vld_d);
		all_d = (cnt_d != '0) && (&(srv_d | ~vld_d));
	end

	// Control state: served marks, count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srv_q <= '0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= run;
			if (run) begin
				srv_q <= srv_d;
				cnt_q <= cnt_d;
			end
		end
	end

	// Identifier cells and result payload.
	always_ff @(posedge clk) begin
		if (run) begin
			ids_q       <= ids_d;
			status      <= st;
			found       <= hit_any;
			entry_count <= oqr_pkg::COUNT_W'(cnt_d);
			any_served  <= any_d;
			all_served  <= all_d;
		end
	end

endmodule

`default_nettype wire

// File: src/ordered_queue_with_removal.sv
// Ordered queue of customer identifiers with served marks, in arrival order.
//
// Command channel: a transaction is taken at a rising edge where start is high
// and busy is low; func selects append, remove first match, mark served,
// membership test or status only, and user_id carries the identifier.
// Result channel: done is high for one cycle with status, found, entry_count,
// any_served and all_served; the receiver takes it in that cycle and cannot
// hold it off.
//
// An accepted transaction is written into the command queue, then executed by the
// back end, which registers its result. Throughput: one transaction per cycle,
// set by the back end, which updates its whole cell row at once; the command queue
// drains every cycle, so busy stays low in normal use.
//
// Reset (arst_n low) empties the queue, clears all served marks and the
// command queue; identifier cells hold no reset value and are never read
// before they are written.
// Depends on oqr_pkg, oqr_front, oqr_cmdq and oqr_back.
`default_nettype none

module ordered_queue_with_removal (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [oqr_pkg::FUNC_W-1:0]    func,
	input  wire logic [oqr_pkg::UID_W-1:0]     user_id,
	output logic                               done,
	output logic [oqr_pkg::STATUS_W-1:0]       status,
	output logic                               found,
	output logic [oqr_pkg::COUNT_W-1:0]        entry_count,
	output logic                               any_served,
	output logic                               all_served
);

	logic               push;
	oqr_pkg::cmd_t      front_cmd;
	oqr_pkg::cmd_t      head_cmd;
	oqr_pkg::cq_flags_t cq_flags;
	logic               run;

	// Classify incoming transactions.
	oqr_front u_front (
		.start    (start),
		.func     (func),
		.user_id  (user_id),
		.cq_flags (cq_flags),
		.busy     (busy),
		.push     (push),
		.cmd      (front_cmd)
	);

	// Buffer commands between the two ends.
	oqr_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (run),
		.head_cmd (head_cmd),
		.flags    (cq_flags)
	);

	// The back end executes one command whenever one is waiting.
	assign run = !cq_flags.empty;

	oqr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.run         (run),
		.cmd         (head_cmd),
		.done        (done),
		.status      (status),
		.found       (found),
		.entry_count (entry_count),
		.any_served  (any_served),
		.all_served  (all_served)
	);

endmodule

`default_nettype wire

// File: src/oqr_checker.sv
// Port-level checks for the ordered queue with removal, bound to the top level.
// Depends on oqr_pkg.
`default_nettype none

module oqr_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic [oqr_pkg::STATUS_W-1:0]  status,
	input wire logic                          found,
	input wire logic [oqr_pkg::COUNT_W-1:0]   entry_count,
	input wire logic                          any_served,
	input wire logic                          all_served
);

	// Every accepted transaction yields its result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result missing two cycles after an accepted transaction");

	// No result appears without a matching accepted transaction.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted transaction");

	// All served implies some served.
	a_all_any: assert property (@(posedge clk) disable iff (!arst_n)
		(done && all_served) |-> any_served)
		else $error("all_served set without any_served");

	// A dropped append only happens with a full queue.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == oqr_pkg::ST_FULL) |->
		(entry_count == oqr_pkg::COUNT_W'(oqr_pkg::DEPTH)))
		else $error("full status with a queue that is not full");

	// A miss never reports the identifier as present.
	a_miss_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == oqr_pkg::ST_MISS) |-> !found)
		else $error("not-found status with found set");

endmodule

bind ordered_queue_with_removal oqr_checker u_oqr_checker (.*);

`default_nettype wire
